// ===== hdl/srp_pkg.sv =====
package srp_pkg;

    localparam int unsigned FQ_DEPTH = 4;
    localparam int unsigned FQ_AW    = $clog2(FQ_DEPTH);
    localparam int unsigned OQ_DEPTH = 2;

    localparam logic [7:0] CH_S = 8'h53;
    localparam logic [7:0] CH_2 = 8'h32;
    localparam logic [7:0] CH_7 = 8'h37;
    localparam logic [7:0] CH_8 = 8'h38;
    localparam logic [7:0] CH_9 = 8'h39;

    localparam logic [3:0] ADDR_DIGITS = 4'd6;
    localparam logic [3:0] WORD_DIGITS = 4'd8;

    localparam logic RK_WRITE = 1'b0;
    localparam logic RK_END   = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TYPE,
        PH_COUNT,
        PH_ADDR,
        PH_DATA
    } t_phase;

    typedef struct packed {
        logic       is_s;
        logic       is_2;
        logic       is_end;
        logic [3:0] nibble;
    } t_tok;

    typedef struct packed {
        logic        kind;
        logic [23:0] addr;
        logic [31:0] data;
        logic        last;
    } t_res;

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [3:0] d;
        d = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            d = c[3:0] + 4'd9;
        end
        return d;
    endfunction

endpackage

// ===== hdl/srp_front.sv =====
module srp_front
    import srp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_char,
    output logic       o_tok_valid,
    output t_tok       o_tok,
    input  logic       i_tok_pop
);

    t_tok               r_mem [FQ_DEPTH];
    logic [FQ_AW-1:0]   r_wp;
    logic [FQ_AW-1:0]   r_rp;
    logic [FQ_AW:0]     r_count;
    logic [FQ_AW:0]     n_count;
    t_tok               w_tok;
    logic               w_wr;
    logic               w_rd;

    // classify the character before it is queued
    always_comb begin
        w_tok.is_s   = (i_in_char == CH_S);
        w_tok.is_2   = (i_in_char == CH_2);
        w_tok.is_end = (i_in_char == CH_7) || (i_in_char == CH_8) || (i_in_char == CH_9);
        w_tok.nibble = hex_nibble(i_in_char);
    end

    assign full        = (r_count == (FQ_AW+1)'(FQ_DEPTH));
    assign w_wr        = push && !full;
    assign o_tok_valid = (r_count != '0);
    assign w_rd        = i_tok_pop && o_tok_valid;
    assign o_tok       = r_mem[r_rp];

    always_comb begin
        n_count = r_count;
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (!w_wr && w_rd) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (w_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= w_tok;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (FQ_AW+1)'(FQ_DEPTH))
        else $error("token queue overfilled");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr && !w_rd) |=> (r_count == $past(r_count) + 1'b1))
        else $error("accepted character lost");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count[FQ_AW-1:0] == FQ_AW'(r_wp - r_rp)))
        else $error("queue pointers disagree with count");

endmodule

// ===== hdl/srp_back.sv =====
module srp_back
    import srp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_tok_valid,
    input  t_tok        i_tok,
    output logic        o_tok_pop,
    output logic        empty,
    input  logic        pop,
    output logic        o_result_kind,
    output logic [23:0] o_write_address,
    output logic [31:0] o_write_data,
    output logic        o_line_last
);

    t_phase      r_phase;
    t_phase      n_phase;
    logic [3:0]  r_dcnt;
    logic [3:0]  n_dcnt;
    logic [3:0]  r_cnt_hi;
    logic [3:0]  n_cnt_hi;
    logic [23:0] r_line_addr;
    logic [23:0] n_line_addr;
    logic [31:0] r_word;
    logic [31:0] n_word;
    logic [7:0]  r_words_done;
    logic [7:0]  n_words_done;
    logic [7:0]  r_words_exp;
    logic [7:0]  n_words_exp;
    logic        r_halted;
    logic        n_halted;

    t_res        r_oq [OQ_DEPTH];
    logic        r_owp;
    logic        r_orp;
    logic [1:0]  r_ocnt;
    logic [1:0]  n_ocnt;

    logic        w_take;
    logic        w_act;
    logic        w_res_valid;
    t_res        w_res;
    logic        w_last;
    logic [7:0]  w_cnt;
    logic [7:0]  w_cnt_m4;
    logic [4:0]  w_sh;
    logic        w_out_rd;

    assign w_take    = i_tok_valid && (r_ocnt != 2'(OQ_DEPTH));
    assign o_tok_pop = w_take;
    assign w_act     = w_take && !r_halted && !i_tok.is_s;
    assign w_last    = ({1'b0, r_words_done} + 9'd1) >= {1'b0, r_words_exp};
    assign w_cnt     = {r_cnt_hi, i_tok.nibble};
    assign w_cnt_m4  = w_cnt - 8'd4;
    assign w_sh      = {r_dcnt[2:1], ~r_dcnt[0], 2'b00};

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (w_take && !r_halted) begin
            if (i_tok.is_s) begin
                n_phase = PH_TYPE;
            end else begin
                unique case (r_phase)
                    PH_IDLE: begin
                        n_phase = PH_IDLE;
                    end
                    PH_TYPE: begin
                        n_phase = i_tok.is_2 ? PH_COUNT : PH_IDLE;
                    end
                    PH_COUNT: begin
                        if (r_dcnt != 4'd0) begin
                            n_phase = PH_ADDR;
                        end
                    end
                    PH_ADDR: begin
                        if (r_dcnt + 4'd1 >= ADDR_DIGITS) begin
                            n_phase = (r_words_exp == 8'd0) ? PH_IDLE : PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        if (r_dcnt + 4'd1 >= WORD_DIGITS && w_last) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // datapath and result
    always_comb begin
        n_dcnt       = r_dcnt;
        n_cnt_hi     = r_cnt_hi;
        n_line_addr  = r_line_addr;
        n_word       = r_word;
        n_words_done = r_words_done;
        n_words_exp  = r_words_exp;
        n_halted     = r_halted;
        w_res_valid  = 1'b0;
        w_res.kind   = RK_WRITE;
        w_res.addr   = r_line_addr + {14'd0, r_words_done, 2'b00};
        w_res.data   = r_word | ({28'd0, i_tok.nibble} << w_sh);
        w_res.last   = w_last;
        if (w_take && !r_halted && i_tok.is_s) begin
            n_dcnt = 4'd0;
        end else if (w_act) begin
            unique case (r_phase)
                PH_IDLE: begin
                end
                PH_TYPE: begin
                    if (i_tok.is_2) begin
                        n_dcnt = 4'd0;
                    end else if (i_tok.is_end) begin
                        n_halted    = 1'b1;
                        w_res_valid = 1'b1;
                        w_res.kind  = RK_END;
                        w_res.addr  = '0;
                        w_res.data  = '0;
                        w_res.last  = 1'b0;
                    end
                end
                PH_COUNT: begin
                    if (r_dcnt == 4'd0) begin
                        n_cnt_hi = i_tok.nibble;
                        n_dcnt   = 4'd1;
                    end else begin
                        n_words_exp = (w_cnt < 8'd4) ? 8'd0 : {2'b00, w_cnt_m4[7:2]};
                        n_dcnt      = 4'd0;
                        n_line_addr = '0;
                    end
                end
                PH_ADDR: begin
                    n_line_addr = {r_line_addr[19:0], i_tok.nibble};
                    n_dcnt      = r_dcnt + 4'd1;
                    if (r_dcnt + 4'd1 >= ADDR_DIGITS) begin
                        n_dcnt       = 4'd0;
                        n_words_done = 8'd0;
                        n_word       = '0;
                    end
                end
                PH_DATA: begin
                    n_word = w_res.data;
                    n_dcnt = r_dcnt + 4'd1;
                    if (r_dcnt + 4'd1 >= WORD_DIGITS) begin
                        w_res_valid  = 1'b1;
                        n_words_done = r_words_done + 8'd1;
                        n_word       = '0;
                        n_dcnt       = 4'd0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_dcnt       <= '0;
            r_cnt_hi     <= '0;
            r_line_addr  <= '0;
            r_word       <= '0;
            r_words_done <= '0;
            r_words_exp  <= '0;
            r_halted     <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_dcnt       <= n_dcnt;
            r_cnt_hi     <= n_cnt_hi;
            r_line_addr  <= n_line_addr;
            r_word       <= n_word;
            r_words_done <= n_words_done;
            r_words_exp  <= n_words_exp;
            r_halted     <= n_halted;
        end
    end

    // result queue
    assign empty    = (r_ocnt == 2'd0);
    assign w_out_rd = pop && !empty;

    always_comb begin
        n_ocnt = r_ocnt;
        if (w_res_valid && !w_out_rd) begin
            n_ocnt = r_ocnt + 2'd1;
        end else if (!w_res_valid && w_out_rd) begin
            n_ocnt = r_ocnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= '0;
        end else begin
            r_ocnt <= n_ocnt;
            if (w_res_valid) begin
                r_owp <= ~r_owp;
            end
            if (w_out_rd) begin
                r_orp <= ~r_orp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_oq[r_owp] <= w_res;
        end
    end

    assign o_result_kind   = r_oq[r_orp].kind;
    assign o_write_address = r_oq[r_orp].addr;
    assign o_write_data    = r_oq[r_orp].data;
    assign o_line_last     = r_oq[r_orp].last;

    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= 2'(OQ_DEPTH))
        else $error("result queue overfilled");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt released");

    a_data_needs_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_words_exp != 8'd0 && r_dcnt < WORD_DIGITS))
        else $error("data phase without expected words");

    a_no_result_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> !w_res_valid)
        else $error("result after halt");

endmodule

// ===== hdl/srec_s2_record_parser.sv =====
// S2 record parser: one ASCII character of an S-record stream per transfer in,
// flash word writes and one end-of-file result out.
// input channel: push with i_in_char while full is low; full rises only when
//   the four-entry character queue cannot take more
// result channel: while empty is low the oldest result sits on o_result_kind,
//   o_write_address, o_write_data and o_line_last; pop takes it
// the front classifies each character (hex value, 'S', '2', end types) and
//   queues it; the back runs the record state machine at one character a cycle
//   while the two-entry result queue it writes results into has room
// throughput: one character per cycle sustained while results are taken
// path: a character that completes a word or an end record passes through the
//   character queue and then the result queue before its result is on the result
//   ports, later while earlier characters still wait in the character queue
// a stalled receiver fills the result queue, the back stops taking
//   characters, the character queue fills and full rises; nothing is lost
// after an S7, S8 or S9 record the end result is queued and every later
//   character is taken and dropped
// reset: both queues empty, parser idle waiting for 'S', halt cleared
module srec_s2_record_parser
    import srp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_in_char,
    output logic        empty,
    input  logic        pop,
    output logic        o_result_kind,
    output logic [23:0] o_write_address,
    output logic [31:0] o_write_data,
    output logic        o_line_last
);

    logic w_tok_valid;
    t_tok w_tok;
    logic w_tok_pop;

    srp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_char   (i_in_char),
        .o_tok_valid (w_tok_valid),
        .o_tok       (w_tok),
        .i_tok_pop   (w_tok_pop)
    );

    srp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_tok_valid     (w_tok_valid),
        .i_tok           (w_tok),
        .o_tok_pop       (w_tok_pop),
        .empty           (empty),
        .pop             (pop),
        .o_result_kind   (o_result_kind),
        .o_write_address (o_write_address),
        .o_write_data    (o_write_data),
        .o_line_last     (o_line_last)
    );

endmodule
